/* rtl/core/mtp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

   // Parser phases
   typedef enum logic [3:0] {
      PH_TAG    = 4'd0,
      PH_CLEN   = 4'd1,
      PH_DELTA  = 4'd2,
      PH_STATUS = 4'd3,
      PH_MTYPE  = 4'd4,
      PH_ELEN   = 4'd5,
      PH_DATA   = 4'd6,
      PH_DONE   = 4'd7,
      PH_HALT   = 4'd8
   } mtp_phase_type;

   // Byte roles reported per transfer
   localparam logic [2:0] ROLE_TAG     = 3'd0;
   localparam logic [2:0] ROLE_CLEN    = 3'd1;
   localparam logic [2:0] ROLE_DELTA   = 3'd2;
   localparam logic [2:0] ROLE_STATUS  = 3'd3;
   localparam logic [2:0] ROLE_MTYPE   = 3'd4;
   localparam logic [2:0] ROLE_ELEN    = 3'd5;
   localparam logic [2:0] ROLE_DATA    = 3'd6;
   localparam logic [2:0] ROLE_IGNORED = 3'd7;

   // Sticky error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_TAG    = 3'd1;
   localparam logic [2:0] ERR_DELTA_LONG = 3'd2;
   localparam logic [2:0] ERR_LEN_LONG   = 3'd3;
   localparam logic [2:0] ERR_BAD_STATUS = 3'd4;
   localparam logic [2:0] ERR_TEMPO      = 3'd5;
   localparam logic [2:0] ERR_LEN_MISMATCH = 3'd6;

   // Status and meta codes
   localparam logic [7:0] ST_META       = 8'hFF;
   localparam logic [7:0] ST_SYSEX      = 8'hF0;
   localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
   localparam logic [3:0] ST_HI_SYSTEM  = 4'hF;
   localparam logic [3:0] ST_HI_PROGRAM = 4'hC;
   localparam logic [3:0] ST_HI_CHPRESS = 4'hD;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;

   // Limits on variable-length quantities and sizes of fixed fields
   localparam logic [3:0] DELTA_MAX_BYTES = 4'd4;
   localparam logic [3:0] LEN_MAX_BYTES   = 4'd8;
   localparam logic [3:0] TAG_BYTES       = 4'd4;
   localparam logic [3:0] CLEN_BYTES      = 4'd4;

   typedef struct packed {
      mtp_phase_type phase;
      logic [3:0]    field_count;
      logic [31:0]   chunk_length;
      logic [31:0]   bytes_seen;
      logic [27:0]   delta_accum;
      logic [63:0]   tick_total;
      logic [7:0]    last_status;
      logic [7:0]    cur_status;
      logic [7:0]    cur_meta;
      logic [55:0]   payload_left;
      logic [2:0]    err;
   } mtp_state_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  event_status;
      logic [7:0]  meta_type;
      logic        event_end;
      logic [63:0] event_ticks;
      logic        track_done;
      logic [2:0]  error_code;
   } mtp_result_type;

   // Expected chunk tag "MTrk"
   function automatic logic [7:0] tag_byte(input logic [1:0] idx);
      logic [7:0] t;
      case (idx)
         2'd0:    t = 8'h4D;
         2'd1:    t = 8'h54;
         2'd2:    t = 8'h72;
         default: t = 8'h6B;
      endcase
      return t;
   endfunction

   function automatic mtp_state_type clear_state();
      mtp_state_type s;
      s.phase        = PH_TAG;
      s.field_count  = 4'd0;
      s.chunk_length = 32'd0;
      s.bytes_seen   = 32'd0;
      s.delta_accum  = 28'd0;
      s.tick_total   = 64'd0;
      s.last_status  = 8'd0;
      s.cur_status   = 8'd0;
      s.cur_meta     = 8'd0;
      s.payload_left = 56'd0;
      s.err          = ERR_NONE;
      return s;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mtp_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtp_step (
   input  wire mtp_pkg::mtp_state_type  state_q,
   input  wire logic [7:0]              byte_value,
   input  wire logic                    restart,
   input  wire logic                    forbid_tempo,
   output mtp_pkg::mtp_state_type       state_d,
   output mtp_pkg::mtp_result_type      result
);
   import mtp_pkg::*;

   mtp_state_type cur;
   mtp_state_type nx;
   mtp_state_type sub;
   logic [2:0]    role;
   logic          ev_end;
   logic          sub_end;
   logic          taken;
   logic [7:0]    st;
   logic [3:0]    fc_inc;
   logic [27:0]   delta_new;

   // Close an event: end of track, forbidden tempo, or back to delta time
   function automatic mtp_state_type finish_ev(input mtp_state_type s, input logic forbid);
      mtp_state_type o;
      o = s;
      o.last_status = s.cur_status;
      if (s.cur_status == ST_META && s.cur_meta == META_EOT) begin
         if (s.bytes_seen == s.chunk_length) begin
            o.phase = PH_DONE;
         end else begin
            o.err   = ERR_LEN_MISMATCH;
            o.phase = PH_HALT;
         end
      end else if (s.cur_status == ST_META && s.cur_meta == META_TEMPO && forbid) begin
         o.err   = ERR_TEMPO;
         o.phase = PH_HALT;
      end else begin
         o.phase       = PH_DELTA;
         o.field_count = 4'd0;
         o.delta_accum = 28'd0;
      end
      return o;
   endfunction

   // One byte of an event length quantity
   function automatic void len_byte(input mtp_state_type s, input logic [7:0] b,
                                    input logic forbid, output mtp_state_type o,
                                    output logic e);
      o = s;
      e = 1'b0;
      if (s.field_count >= LEN_MAX_BYTES) begin
         o.err   = ERR_LEN_LONG;
         o.phase = PH_HALT;
      end else begin
         o.field_count  = s.field_count + 4'd1;
         o.payload_left = {s.payload_left[48:0], b[6:0]};
         if (!b[7]) begin
            if (o.payload_left == 56'd0) begin
               o = finish_ev(o, forbid);
               e = 1'b1;
            end else begin
               o.phase = PH_DATA;
            end
         end
      end
   endfunction

   // One data byte of an event
   function automatic void data_byte(input mtp_state_type s, input logic forbid,
                                     output mtp_state_type o, output logic e);
      o = s;
      e = 1'b0;
      o.payload_left = s.payload_left - 56'd1;
      if (o.payload_left == 56'd0) begin
         o = finish_ev(o, forbid);
         e = 1'b1;
      end
   endfunction

   always_comb begin
      cur       = restart ? clear_state() : state_q;
      nx        = cur;
      sub       = cur;
      sub_end   = 1'b0;
      role      = ROLE_IGNORED;
      ev_end    = 1'b0;
      taken     = byte_value[7];
      st        = taken ? byte_value : cur.last_status;
      fc_inc    = cur.field_count + 4'd1;
      delta_new = {cur.delta_accum[20:0], byte_value[6:0]};

      // Count bytes inside the event stream
      if (cur.phase == PH_DELTA || cur.phase == PH_STATUS || cur.phase == PH_MTYPE ||
          cur.phase == PH_ELEN || cur.phase == PH_DATA) begin
         nx.bytes_seen = cur.bytes_seen + 32'd1;
      end

      case (cur.phase)
         PH_TAG: begin
            role = ROLE_TAG;
            if (byte_value != tag_byte(cur.field_count[1:0])) begin
               nx.err   = ERR_BAD_TAG;
               nx.phase = PH_HALT;
            end else begin
               nx.field_count = fc_inc;
               if (fc_inc >= TAG_BYTES) begin
                  nx.phase       = PH_CLEN;
                  nx.field_count = 4'd0;
               end
            end
         end
         PH_CLEN: begin
            role = ROLE_CLEN;
            nx.chunk_length = {cur.chunk_length[23:0], byte_value};
            nx.field_count  = fc_inc;
            if (fc_inc >= CLEN_BYTES) begin
               nx.phase       = PH_DELTA;
               nx.field_count = 4'd0;
               nx.bytes_seen  = 32'd0;
               nx.delta_accum = 28'd0;
            end
         end
         PH_DELTA: begin
            role = ROLE_DELTA;
            if (cur.field_count >= DELTA_MAX_BYTES) begin
               nx.err   = ERR_DELTA_LONG;
               nx.phase = PH_HALT;
            end else begin
               nx.field_count = fc_inc;
               nx.delta_accum = delta_new;
               if (!byte_value[7]) begin
                  nx.tick_total = cur.tick_total + {36'd0, delta_new};
                  nx.phase      = PH_STATUS;
               end
            end
         end
         PH_STATUS: begin
            role          = ROLE_STATUS;
            nx.cur_status = st;
            nx.cur_meta   = 8'd0;
            if (st == ST_META) begin
               if (taken) begin
                  nx.phase = PH_MTYPE;
               end else begin
                  // Running meta status: this byte is the type
                  role            = ROLE_MTYPE;
                  nx.cur_meta     = byte_value;
                  nx.field_count  = 4'd0;
                  nx.payload_left = 56'd0;
                  nx.phase        = PH_ELEN;
               end
            end else if (st == ST_SYSEX || st == ST_SYSEX_ESC) begin
               nx.field_count  = 4'd0;
               nx.payload_left = 56'd0;
               nx.phase        = PH_ELEN;
               if (!taken) begin
                  role = ROLE_ELEN;
                  len_byte(nx, byte_value, forbid_tempo, sub, sub_end);
                  nx     = sub;
                  ev_end = sub_end;
               end
            end else if (st[7] && st[7:4] != ST_HI_SYSTEM) begin
               nx.payload_left = (st[7:4] == ST_HI_PROGRAM || st[7:4] == ST_HI_CHPRESS) ?
                                 56'd1 : 56'd2;
               nx.phase = PH_DATA;
               if (!taken) begin
                  role = ROLE_DATA;
                  data_byte(nx, forbid_tempo, sub, sub_end);
                  nx     = sub;
                  ev_end = sub_end;
               end
            end else begin
               nx.err   = ERR_BAD_STATUS;
               nx.phase = PH_HALT;
            end
         end
         PH_MTYPE: begin
            role            = ROLE_MTYPE;
            nx.cur_meta     = byte_value;
            nx.field_count  = 4'd0;
            nx.payload_left = 56'd0;
            nx.phase        = PH_ELEN;
         end
         PH_ELEN: begin
            role = ROLE_ELEN;
            len_byte(nx, byte_value, forbid_tempo, sub, sub_end);
            nx     = sub;
            ev_end = sub_end;
         end
         PH_DATA: begin
            role = ROLE_DATA;
            data_byte(nx, forbid_tempo, sub, sub_end);
            nx     = sub;
            ev_end = sub_end;
         end
         default: begin
            // Done or halted: ignore the byte
            role = ROLE_IGNORED;
         end
      endcase

      state_d             = nx;
      result.byte_role    = role;
      result.event_status = nx.cur_status;
      result.meta_type    = nx.cur_meta;
      result.event_end    = ev_end;
      result.event_ticks  = nx.tick_total;
      result.track_done   = (nx.phase == PH_DONE);
      result.error_code   = nx.err;
   end

endmodule

`default_nettype wire

/* rtl/core/midi_track_event_parser_unit.sv */
// A result is registered and appears on rsp_ in the cycle after its req_ transfer.
// Throughput: one byte per cycle while the result register is free or draining;
// the parser state register closes its loop through one decode step per byte.
// Reset (synchronous, active high) clears the parser state, forbid_tempo
// and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_byte_role,
   output logic [7:0]       rsp_event_status,
   output logic [7:0]       rsp_meta_type,
   output logic             rsp_event_end,
   output logic [63:0]      rsp_event_ticks,
   output logic             rsp_track_done,
   output logic [2:0]       rsp_error_code,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import mtp_pkg::*;

   mtp_state_type  state_ff;
   mtp_state_type  state_in;
   mtp_result_type result_ff;
   mtp_result_type result_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           forbid_ff;
   logic           accept;

   // Take a byte whenever the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   mtp_step u_step (
      .state_q      (state_ff),
      .byte_value   (req_byte_value),
      .restart      (req_restart),
      .forbid_tempo (forbid_ff),
      .state_d      (state_in),
      .result       (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Advance parser state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clear_state();
         rsp_valid_ff <= 1'b0;
         forbid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            forbid_ff <= csr_wr_data;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_role    = result_ff.byte_role;
   assign rsp_event_status = result_ff.event_status;
   assign rsp_meta_type    = result_ff.meta_type;
   assign rsp_event_end    = result_ff.event_end;
   assign rsp_event_ticks  = result_ff.event_ticks;
   assign rsp_track_done   = result_ff.track_done;
   assign rsp_error_code   = result_ff.error_code;

endmodule

`default_nettype wire

/* rtl/core/mtp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_byte_value,
   input wire logic        req_restart,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_byte_role,
   input wire logic [7:0]  rsp_event_status,
   input wire logic [7:0]  rsp_meta_type,
   input wire logic        rsp_event_end,
   input wire logic [63:0] rsp_event_ticks,
   input wire logic        rsp_track_done,
   input wire logic [2:0]  rsp_error_code,
   input wire logic        csr_wr_en,
   input wire logic        csr_wr_data
);
   import mtp_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_role) &&
      $stable(rsp_event_ticks) && $stable(rsp_error_code))
      else $error("stalled result changed");

   // Every input transfer yields a result next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("input transfer produced no result");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Ignored bytes only after an error or end of track
   a_ignored_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == ROLE_IGNORED |->
      rsp_error_code != ERR_NONE || rsp_track_done)
      else $error("byte ignored without error or end of track");

   // Events end only on a length or data byte, and done means clean
   a_end_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_end || rsp_track_done) |->
      (rsp_byte_role == ROLE_ELEN || rsp_byte_role == ROLE_DATA ||
       rsp_byte_role == ROLE_IGNORED) && !(rsp_track_done && rsp_error_code != ERR_NONE))
      else $error("event end on unexpected byte role");

endmodule

bind midi_track_event_parser_unit mtp_checker u_mtp_checker (.*);

`default_nettype wire
